[hdl/hae_pkg.sv]
package hae_pkg;

  localparam int COORD_WIDTH     = 32;
  localparam int ACOS_ITERATIONS = 24;

  // arm formation and normalization
  localparam int DIFF_W  = COORD_WIDTH + 1;
  localparam int MSB_W   = $clog2(DIFF_W);
  localparam int NORM_W  = 30;
  localparam int SHIFT_W = DIFF_W + NORM_W;
  localparam int PROD_W  = 2 * NORM_W;
  localparam int SUM_W   = PROD_W + 2;

  // floor square root, one result bit per cell
  localparam int ROOT_W     = SUM_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int DEN_W      = 2 * ROOT_W;

  // cosine divider, one quotient bit per cell
  localparam int DIV_STEPS = 30;
  localparam int DIVR_W    = DEN_W + 1;
  localparam int Q_W       = DIV_STEPS + 1;

  // arccos rotation cells
  localparam int CORD_W  = 34;
  localparam int IDX_W   = $clog2(ACOS_ITERATIONS);
  localparam int THETA_W = CORD_W + 1;

  // energy path
  localparam int K_W      = 32;
  localparam int REST_W   = 24;
  localparam int T0_W     = 34;
  localparam int DELTA_W  = THETA_W + 1;
  localparam int D24_W    = 29;
  localparam int SQ_W     = 2 * D24_W - 16;
  localparam int SH_W     = SQ_W - 32;
  localparam int E_W      = K_W + SH_W + 1;
  localparam int ENERGY_W = 40;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam int LATENCY = 13 + 2 * SQRT_STEPS + DIV_STEPS + ACOS_ITERATIONS;

  localparam logic [63:0] DEG2RAD_Q44 = 64'd307041569098;
  localparam int DEG_LO_W = 20;
  localparam int DEG_HI_W = 19;
  localparam logic [DEG_HI_W-1:0] DEG_HI = DEG_HI_W'(DEG2RAD_Q44 >> DEG_LO_W);
  localparam logic [DEG_LO_W-1:0] DEG_LO = DEG_LO_W'(DEG2RAD_Q44);

  localparam logic signed [THETA_W-1:0] PI_Q30 = THETA_W'(64'd3373259426);

  typedef enum logic {
    REG_FORCE_CONSTANT = 1'b0,
    REG_REST_ANGLE     = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic cneg;
    logic degen;
  } side_t;

  localparam logic [CORD_W-1:0] ATAN_LOW [10] = '{
    CORD_W'(64'd843314857), CORD_W'(64'd497837829), CORD_W'(64'd263043837),
    CORD_W'(64'd133525159), CORD_W'(64'd67021687),  CORD_W'(64'd33543516),
    CORD_W'(64'd16775851),  CORD_W'(64'd8388437),   CORD_W'(64'd4194283),
    CORD_W'(64'd2097149)
  };

  // atan(2^-i) in Q30 radians
  function automatic logic signed [CORD_W-1:0] atan_entry(input int i);
    logic signed [CORD_W-1:0] v;
    if (i < 10) begin
      v = signed'(ATAN_LOW[i]);
    end else if (i <= 30) begin
      v = CORD_W'(64'd1 << (30 - i));
    end else begin
      v = '0;
    end
    return v;
  endfunction

endpackage

[hdl/hae_sqrt_cell.sv]
module hae_sqrt_cell (
  input  logic                       clk,
  input  logic [hae_pkg::SUM_W-1:0]  n_i,
  input  logic [hae_pkg::REM_W-1:0]  rem_i,
  input  logic [hae_pkg::ROOT_W-1:0] root_i,
  output logic [hae_pkg::SUM_W-1:0]  n_o,
  output logic [hae_pkg::REM_W-1:0]  rem_o,
  output logic [hae_pkg::ROOT_W-1:0] root_o
);
  import hae_pkg::*;

  logic [REM_W+1:0] rem2;
  logic [REM_W+1:0] trial;
  logic             ge;
  logic [REM_W+1:0] diff;

  // bring down two radicand bits, try the next root bit
  assign rem2  = {rem_i, n_i[SUM_W-1 -: 2]};
  assign trial = {2'b00, root_i, 2'b01};
  assign ge    = rem2 >= trial;
  assign diff  = rem2 - trial;

  always_ff @(posedge clk) begin
    n_o    <= {n_i[SUM_W-3:0], 2'b00};
    rem_o  <= ge ? diff[REM_W-1:0] : rem2[REM_W-1:0];
    root_o <= {root_i[ROOT_W-2:0], ge};
  end

endmodule

[hdl/hae_div_cell.sv]
module hae_div_cell (
  input  logic                       clk,
  input  logic [hae_pkg::DIVR_W-1:0] r_i,
  input  logic [hae_pkg::DEN_W-1:0]  den_i,
  input  logic [hae_pkg::Q_W-1:0]    q_i,
  input  logic                       done_i,
  output logic [hae_pkg::DIVR_W-1:0] r_o,
  output logic [hae_pkg::DEN_W-1:0]  den_o,
  output logic [hae_pkg::Q_W-1:0]    q_o,
  output logic                       done_o
);
  import hae_pkg::*;

  logic [DIVR_W-1:0] r2;
  logic              ge;

  assign r2 = {r_i[DIVR_W-2:0], 1'b0};
  assign ge = r2 >= {1'b0, den_i};

  always_ff @(posedge clk) begin
    den_o  <= den_i;
    done_o <= done_i;
    if (done_i) begin
      r_o <= r_i;
      q_o <= q_i;
    end else begin
      r_o <= ge ? r2 - {1'b0, den_i} : r2;
      q_o <= {q_i[Q_W-2:0], ge};
    end
  end

endmodule

[hdl/hae_cordic_cell.sv]
module hae_cordic_cell (
  input  logic                              clk,
  input  logic [hae_pkg::IDX_W-1:0]         idx_i,
  input  logic signed [hae_pkg::CORD_W-1:0] x_i,
  input  logic signed [hae_pkg::CORD_W-1:0] y_i,
  input  logic signed [hae_pkg::CORD_W-1:0] z_i,
  output logic signed [hae_pkg::CORD_W-1:0] x_o,
  output logic signed [hae_pkg::CORD_W-1:0] y_o,
  output logic signed [hae_pkg::CORD_W-1:0] z_o
);
  import hae_pkg::*;

  logic signed [CORD_W-1:0] xs;
  logic signed [CORD_W-1:0] ys;
  logic signed [CORD_W-1:0] ang;

  assign xs  = x_i >>> idx_i;
  assign ys  = y_i >>> idx_i;
  assign ang = atan_entry(int'(idx_i));

  // rotate toward y = 0, accumulate the angle
  always_ff @(posedge clk) begin
    if (!y_i[CORD_W-1]) begin
      x_o <= x_i + ys;
      y_o <= y_i - xs;
      z_o <= z_i + ang;
    end else begin
      x_o <= x_i - ys;
      y_o <= y_i + xs;
      z_o <= z_i - ang;
    end
  end

endmodule

[hdl/harmonic_angle_energy_top.sv]
// Channel  Ports                                  Handshake
// input    in_atom1_*, in_center_*, in_atom3_*    start & !busy, transfer each cycle
// result   out_energy, out_degenerate_arm,        out_valid strobe, one cycle
//          out_saturated
// config   psel penable pwrite paddr pwdata       APB, pready always high
//
// One triple is accepted every cycle; busy stays low.
// The pipeline runs through two 31-cell square-root chains in series, the
// 30-cell divider chain and 24 arccos rotation cells, plus 13 arithmetic stages.
// rst_n clears the valid pipe and the registers; data stages hold no reset.
// Results are strobed for one cycle and cannot be stalled.
module harmonic_angle_energy_top (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  output logic                                    busy,
  input  logic signed [hae_pkg::COORD_WIDTH-1:0]  in_atom1_x,
  input  logic signed [hae_pkg::COORD_WIDTH-1:0]  in_atom1_y,
  input  logic signed [hae_pkg::COORD_WIDTH-1:0]  in_atom1_z,
  input  logic signed [hae_pkg::COORD_WIDTH-1:0]  in_center_x,
  input  logic signed [hae_pkg::COORD_WIDTH-1:0]  in_center_y,
  input  logic signed [hae_pkg::COORD_WIDTH-1:0]  in_center_z,
  input  logic signed [hae_pkg::COORD_WIDTH-1:0]  in_atom3_x,
  input  logic signed [hae_pkg::COORD_WIDTH-1:0]  in_atom3_y,
  input  logic signed [hae_pkg::COORD_WIDTH-1:0]  in_atom3_z,
  output logic                                    out_valid,
  output logic [hae_pkg::ENERGY_W-1:0]            out_energy,
  output logic                                    out_degenerate_arm,
  output logic                                    out_saturated,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [hae_pkg::CFG_ADDR_W-1:0]          paddr,
  input  logic [hae_pkg::CFG_DATA_W-1:0]          pwdata,
  output logic [hae_pkg::CFG_DATA_W-1:0]          prdata,
  output logic                                    pready
);
  import hae_pkg::*;

  localparam int S = SQRT_STEPS;
  localparam int D = DIV_STEPS;
  localparam int A = ACOS_ITERATIONS;

  // ---------------- configuration ----------------
  logic [K_W-1:0]    force_constant_r;
  logic [REST_W-1:0] rest_angle_r;
  reg_idx_t          cfg_idx;
  logic              cfg_wr;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign cfg_idx = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      force_constant_r <= '0;
      rest_angle_r     <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FORCE_CONSTANT: force_constant_r <= pwdata[K_W-1:0];
        REG_REST_ANGLE:     rest_angle_r     <= pwdata[REST_W-1:0];
        default:            ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FORCE_CONSTANT: prdata = CFG_DATA_W'(force_constant_r);
      REG_REST_ANGLE:     prdata = CFG_DATA_W'(rest_angle_r);
      default:            prdata = '0;
    endcase
  end

  // rest angle to Q30 radians, settles long before any item needs it
  logic [REST_W+DEG_HI_W-1:0] t0_hi_r;
  logic [REST_W+DEG_LO_W-1:0] t0_lo_r;
  logic [63:0]                t0_sum;
  logic [T0_W-1:0]            theta0_r;

  assign t0_sum = (64'(t0_hi_r) << DEG_LO_W) + 64'(t0_lo_r) + (64'd1 << 29);

  always_ff @(posedge clk) begin
    t0_hi_r  <= rest_angle_r * DEG_HI;
    t0_lo_r  <= rest_angle_r * DEG_LO;
    theta0_r <= T0_W'(t0_sum >> 30);
  end

  // ---------------- valid pipe ----------------
  logic [LATENCY-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= {valid_r[LATENCY-2:0], start & ~busy};
    end
  end

  assign out_valid = valid_r[LATENCY-1];

  // ---------------- arm formation ----------------
  logic signed [COORD_WIDTH-1:0] ends [2][3];
  logic signed [COORD_WIDTH-1:0] ctr  [3];

  assign ends[0][0] = in_atom1_x;
  assign ends[0][1] = in_atom1_y;
  assign ends[0][2] = in_atom1_z;
  assign ends[1][0] = in_atom3_x;
  assign ends[1][1] = in_atom3_y;
  assign ends[1][2] = in_atom3_z;
  assign ctr[0]     = in_center_x;
  assign ctr[1]     = in_center_y;
  assign ctr[2]     = in_center_z;

  logic [DIFF_W-1:0] mag1_r [2][3];
  logic              neg1_r [2][3];
  logic [DIFF_W-1:0] mag2_r [2][3];
  logic              neg2_r [2][3];
  logic [MSB_W-1:0]  msb2_r [2];
  logic              dg2_r  [2];
  logic [NORM_W-1:0] mag3_r [2][3];
  logic              neg3_r [2][3];
  logic              dg3_r;

  always_ff @(posedge clk) begin
    for (int a = 0; a < 2; a++) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [DIFF_W-1:0] d;
        d = DIFF_W'(ends[a][k]) - DIFF_W'(ctr[k]);
        neg1_r[a][k] <= d[DIFF_W-1];
        mag1_r[a][k] <= d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
      end
    end
  end

  // find the leading one of each arm
  always_ff @(posedge clk) begin
    for (int a = 0; a < 2; a++) begin
      logic [DIFF_W-1:0] m;
      logic [MSB_W-1:0]  p;
      m = mag1_r[a][0] | mag1_r[a][1] | mag1_r[a][2];
      p = '0;
      for (int b = 0; b < DIFF_W; b++) begin
        if (m[b]) p = MSB_W'(b);
      end
      msb2_r[a] <= p;
      dg2_r[a]  <= (m == '0);
      for (int k = 0; k < 3; k++) begin
        mag2_r[a][k] <= mag1_r[a][k];
        neg2_r[a][k] <= neg1_r[a][k];
      end
    end
  end

  // scale each arm so its largest component lies in [2^29, 2^30)
  always_ff @(posedge clk) begin
    for (int a = 0; a < 2; a++) begin
      for (int k = 0; k < 3; k++) begin
        logic [SHIFT_W-1:0] wide;
        wide = SHIFT_W'(mag2_r[a][k]);
        if (int'(msb2_r[a]) > NORM_W - 1) begin
          wide = wide >> (int'(msb2_r[a]) - (NORM_W - 1));
        end else begin
          wide = wide << ((NORM_W - 1) - int'(msb2_r[a]));
        end
        mag3_r[a][k] <= wide[NORM_W-1:0];
        neg3_r[a][k] <= neg2_r[a][k];
      end
    end
    dg3_r <= dg2_r[0] | dg2_r[1];
  end

  // ---------------- dot product and squared lengths ----------------
  logic [PROD_W-1:0] pd4_r [3];
  logic              sd4_r [3];
  logic [PROD_W-1:0] pu4_r [3];
  logic [PROD_W-1:0] pw4_r [3];
  logic              dg4_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      pd4_r[k] <= mag3_r[0][k] * mag3_r[1][k];
      sd4_r[k] <= neg3_r[0][k] ^ neg3_r[1][k];
      pu4_r[k] <= mag3_r[0][k] * mag3_r[0][k];
      pw4_r[k] <= mag3_r[1][k] * mag3_r[1][k];
    end
    dg4_r <= dg3_r;
  end

  logic [SUM_W-1:0] dmag5_r;
  logic [SUM_W-1:0] nu5_r;
  logic [SUM_W-1:0] nw5_r;
  side_t            side5_r;

  always_ff @(posedge clk) begin
    logic signed [SUM_W:0] dot;
    dot = '0;
    for (int k = 0; k < 3; k++) begin
      dot = sd4_r[k] ? dot - (SUM_W + 1)'(pd4_r[k]) : dot + (SUM_W + 1)'(pd4_r[k]);
    end
    dmag5_r       <= dot[SUM_W] ? SUM_W'(-dot) : SUM_W'(dot);
    side5_r.cneg  <= dot[SUM_W] & ~dg4_r;
    side5_r.degen <= dg4_r;
    nu5_r <= SUM_W'(pu4_r[0]) + SUM_W'(pu4_r[1]) + SUM_W'(pu4_r[2]);
    nw5_r <= SUM_W'(pw4_r[0]) + SUM_W'(pw4_r[1]) + SUM_W'(pw4_r[2]);
  end

  // ---------------- arm lengths ----------------
  logic [SUM_W-1:0]  su_n    [S+1];
  logic [REM_W-1:0]  su_rem  [S+1];
  logic [ROOT_W-1:0] su_root [S+1];
  logic [SUM_W-1:0]  sw_n    [S+1];
  logic [REM_W-1:0]  sw_rem  [S+1];
  logic [ROOT_W-1:0] sw_root [S+1];
  logic [SUM_W-1:0]  s1_dmag [S+1];
  side_t             s1_side [S+1];

  assign su_n[0]    = nu5_r;
  assign su_rem[0]  = '0;
  assign su_root[0] = '0;
  assign sw_n[0]    = nw5_r;
  assign sw_rem[0]  = '0;
  assign sw_root[0] = '0;
  assign s1_dmag[0] = dmag5_r;
  assign s1_side[0] = side5_r;

  for (genvar i = 0; i < S; i++) begin : g_len
    hae_sqrt_cell u_sq_u (
      .clk   (clk),
      .n_i   (su_n[i]),
      .rem_i (su_rem[i]),
      .root_i(su_root[i]),
      .n_o   (su_n[i+1]),
      .rem_o (su_rem[i+1]),
      .root_o(su_root[i+1])
    );
    hae_sqrt_cell u_sq_w (
      .clk   (clk),
      .n_i   (sw_n[i]),
      .rem_i (sw_rem[i]),
      .root_i(sw_root[i]),
      .n_o   (sw_n[i+1]),
      .rem_o (sw_rem[i+1]),
      .root_o(sw_root[i+1])
    );
    always_ff @(posedge clk) begin
      s1_dmag[i+1] <= s1_dmag[i];
      s1_side[i+1] <= s1_side[i];
    end
  end

  logic [DEN_W-1:0] den6_r;
  logic [SUM_W-1:0] dmag6_r;
  side_t            side6_r;

  always_ff @(posedge clk) begin
    den6_r  <= su_root[S] * sw_root[S];
    dmag6_r <= s1_dmag[S];
    side6_r <= s1_side[S];
  end

  // ---------------- cosine divider ----------------
  logic [DIVR_W-1:0] dv_r    [D+1];
  logic [DEN_W-1:0]  dv_den  [D+1];
  logic [Q_W-1:0]    dv_q    [D+1];
  logic              dv_done [D+1];
  side_t             dv_side [D+1];

  // degenerate arm gives a zero cosine; |dot| at or past the bound clamps to one
  always_ff @(posedge clk) begin
    dv_r[0]    <= DIVR_W'(dmag6_r);
    dv_den[0]  <= den6_r;
    dv_side[0] <= side6_r;
    if (side6_r.degen) begin
      dv_q[0]    <= '0;
      dv_done[0] <= 1'b1;
    end else if (DEN_W'(dmag6_r) >= den6_r) begin
      dv_q[0]    <= Q_W'(64'd1 << 30);
      dv_done[0] <= 1'b1;
    end else begin
      dv_q[0]    <= '0;
      dv_done[0] <= 1'b0;
    end
  end

  for (genvar i = 0; i < D; i++) begin : g_div
    hae_div_cell u_div (
      .clk   (clk),
      .r_i   (dv_r[i]),
      .den_i (dv_den[i]),
      .q_i   (dv_q[i]),
      .done_i(dv_done[i]),
      .r_o   (dv_r[i+1]),
      .den_o (dv_den[i+1]),
      .q_o   (dv_q[i+1]),
      .done_o(dv_done[i+1])
    );
    always_ff @(posedge clk) begin
      dv_side[i+1] <= dv_side[i];
    end
  end

  // ---------------- sine from cosine ----------------
  logic [Q_W-1:0]   c8_r;
  logic [SUM_W-1:0] ss8_r;
  side_t            side8_r;

  always_ff @(posedge clk) begin
    c8_r    <= dv_q[D];
    ss8_r   <= (SUM_W'(1) << 60) - SUM_W'(dv_q[D]) * SUM_W'(dv_q[D]);
    side8_r <= dv_side[D];
  end

  logic [SUM_W-1:0]  ss_n    [S+1];
  logic [REM_W-1:0]  ss_rem  [S+1];
  logic [ROOT_W-1:0] ss_root [S+1];
  logic [Q_W-1:0]    s2_c    [S+1];
  side_t             s2_side [S+1];

  assign ss_n[0]    = ss8_r;
  assign ss_rem[0]  = '0;
  assign ss_root[0] = '0;
  assign s2_c[0]    = c8_r;
  assign s2_side[0] = side8_r;

  for (genvar i = 0; i < S; i++) begin : g_sin
    hae_sqrt_cell u_sq_s (
      .clk   (clk),
      .n_i   (ss_n[i]),
      .rem_i (ss_rem[i]),
      .root_i(ss_root[i]),
      .n_o   (ss_n[i+1]),
      .rem_o (ss_rem[i+1]),
      .root_o(ss_root[i+1])
    );
    always_ff @(posedge clk) begin
      s2_c[i+1]    <= s2_c[i];
      s2_side[i+1] <= s2_side[i];
    end
  end

  // ---------------- arccos rotations ----------------
  logic signed [CORD_W-1:0] cx    [A+1];
  logic signed [CORD_W-1:0] cy    [A+1];
  logic signed [CORD_W-1:0] cz    [A+1];
  side_t                    cside [A+1];

  assign cx[0]    = CORD_W'(s2_c[S]);
  assign cy[0]    = CORD_W'(ss_root[S]);
  assign cz[0]    = '0;
  assign cside[0] = s2_side[S];

  for (genvar i = 0; i < A; i++) begin : g_acos
    hae_cordic_cell u_rot (
      .clk  (clk),
      .idx_i(IDX_W'(i)),
      .x_i  (cx[i]),
      .y_i  (cy[i]),
      .z_i  (cz[i]),
      .x_o  (cx[i+1]),
      .y_o  (cy[i+1]),
      .z_o  (cz[i+1])
    );
    always_ff @(posedge clk) begin
      cside[i+1] <= cside[i];
    end
  end

  // ---------------- energy ----------------
  logic signed [THETA_W-1:0] theta_r;
  side_t                     side_t_r;

  always_ff @(posedge clk) begin
    theta_r  <= cside[A].cneg ? PI_Q30 - THETA_W'(cz[A]) : THETA_W'(cz[A]);
    side_t_r <= cside[A];
  end

  logic [D24_W-1:0] d24_r;
  side_t            side_d_r;

  always_ff @(posedge clk) begin
    logic signed [DELTA_W-1:0] delta;
    logic [DELTA_W-1:0]        ad;
    delta    = DELTA_W'(theta_r) - signed'(DELTA_W'(theta0_r));
    ad       = delta[DELTA_W-1] ? DELTA_W'(-delta) : DELTA_W'(delta);
    d24_r    <= D24_W'((ad + DELTA_W'(32)) >> 6);
    side_d_r <= side_t_r;
  end

  logic [SQ_W-1:0] sq_r;
  side_t           side_q_r;

  always_ff @(posedge clk) begin
    sq_r     <= SQ_W'(((2 * D24_W)'(d24_r) * (2 * D24_W)'(d24_r)
                       + (2 * D24_W)'(1 << 15)) >> 16);
    side_q_r <= side_d_r;
  end

  logic [K_W+SH_W-1:0] ph_r;
  logic [2*K_W-1:0]    pl_r;
  side_t               side_p_r;

  always_ff @(posedge clk) begin
    ph_r     <= force_constant_r * sq_r[SQ_W-1:32];
    pl_r     <= force_constant_r * sq_r[31:0];
    side_p_r <= side_q_r;
  end

  always_ff @(posedge clk) begin
    logic [2*K_W:0] lo_sum;
    logic [E_W-1:0] e;
    lo_sum = (2 * K_W + 1)'(pl_r) + (2 * K_W + 1)'(64'd1 << 31);
    e      = E_W'(ph_r) + E_W'(lo_sum >> 32);
    // clip above the output range
    if (e[E_W-1:ENERGY_W] != '0) begin
      out_energy    <= '1;
      out_saturated <= 1'b1;
    end else begin
      out_energy    <= e[ENERGY_W-1:0];
      out_saturated <= 1'b0;
    end
    out_degenerate_arm <= side_p_r.degen;
  end

endmodule
